// ===== src/ccsd_pkg.sv =====
// Shared types, constants and lookup tables for the chain code shape descriptor block.
package ccsd_pkg;

  localparam int COORD_BITS = 12;
  localparam int MAX_CODES  = 65535;
  localparam int CNT_W      = $clog2(MAX_CODES + 2);
  localparam int POS_W      = ((CNT_W > COORD_BITS) ? CNT_W : COORD_BITS) + 2;
  localparam int AREA_W     = 2 * CNT_W + 2;
  localparam int CROSS_W    = CNT_W + 2;
  localparam int CFG_IDX_W  = 2;

  localparam int STEPS_W  = 16;
  localparam int PER_W    = 25;
  localparam int AT_W     = 26;
  localparam int AB_W     = 33;
  localparam int PIX_W    = 25;
  localparam int BOX_W    = 12;
  localparam int PER_CALC_W = CNT_W + 10;
  localparam int AB_CALC_W  = AB_W + 3;

  localparam logic [CNT_W-1:0]      STEPS_MAX = CNT_W'(65535);
  localparam logic [PER_CALC_W-1:0] PER_MAX   = PER_CALC_W'(33554431);
  localparam logic [AREA_W-1:0]     AT_MAX    = AREA_W'(33554432);
  localparam logic [AB_CALC_W-1:0]  AB_MAX    = AB_CALC_W'(64'd8589934591);
  localparam logic [AREA_W-1:0]     PIX_MAX   = AREA_W'(16777216);
  localparam logic [CNT_W-1:0]      CODE_LIMIT = CNT_W'(MAX_CODES);
  localparam logic signed [POS_W-1:0] COORD_TOP = POS_W'((1 << COORD_BITS) - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X = 2'd0,
    CFG_START_Y = 2'd1,
    CFG_QUERY_X = 2'd2,
    CFG_QUERY_Y = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CT_DEC  = 2'd0,
    CT_INC  = 2'd1,
    CT_NONE = 2'd2,
    CT_ONE  = 2'd3
  } corner_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] query_x;
    logic [COORD_BITS-1:0] query_y;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]         even;
    logic [CNT_W-1:0]         odd;
    logic signed [AREA_W-1:0] area;
    logic signed [AREA_W-1:0] pix;
    logic signed [POS_W-1:0]  min_x;
    logic signed [POS_W-1:0]  max_x;
    logic signed [POS_W-1:0]  min_y;
    logic signed [POS_W-1:0]  max_y;
    logic                     enclosed;
  } raw_t;

  localparam logic signed [1:0] STEP_DX [8] = '{2'sd1, 2'sd1, 2'sd0, -2'sd1,
                                                -2'sd1, -2'sd1, 2'sd0, 2'sd1};
  localparam logic signed [1:0] STEP_DY [8] = '{2'sd0, -2'sd1, -2'sd1, -2'sd1,
                                                2'sd0, 2'sd1, 2'sd1, 2'sd1};

  localparam logic [1:0] CORNER_TYPE [8][8] = '{
    '{2'd1, 2'd1, 2'd1, 2'd3, 2'd3, 2'd2, 2'd2, 2'd1},
    '{2'd1, 2'd1, 2'd1, 2'd3, 2'd3, 2'd3, 2'd2, 2'd1},
    '{2'd2, 2'd2, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2},
    '{2'd2, 2'd2, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd3},
    '{2'd3, 2'd2, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd3},
    '{2'd3, 2'd3, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd3},
    '{2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1},
    '{2'd1, 2'd1, 2'd1, 2'd3, 2'd2, 2'd2, 2'd2, 2'd1}
  };

  localparam logic signed [1:0] CROSS_ROW [8][8] = '{
    '{2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd0},
    '{2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd0},
    '{2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd0},
    '{2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd1, 2'sd0, 2'sd0, 2'sd0},
    '{-2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, -2'sd1, -2'sd1, -2'sd1},
    '{-2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, -2'sd1, -2'sd1, -2'sd1},
    '{-2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, -2'sd1, -2'sd1, -2'sd1},
    '{-2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, -2'sd1, -2'sd1, -2'sd1}
  };

  localparam logic [7:0] CROSS_HIT [8] = '{
    8'b0000_0000, 8'b0010_0000, 8'b0110_0000, 8'b1110_0000,
    8'b1110_0001, 8'b1110_0011, 8'b1110_0111, 8'b1110_1111
  };

  function automatic logic signed [CROSS_W-1:0] cross_term(
    input logic v, input logic j, input logic [2:0] pre, input logic [2:0] cur);
    logic signed [CROSS_W-1:0] row;
    logic signed [CROSS_W-1:0] hit;
    row = v ? CROSS_W'(CROSS_ROW[pre][cur]) : '0;
    hit = (j && CROSS_HIT[pre][cur]) ? CROSS_W'(1) : '0;
    return row + hit;
  endfunction

endpackage

// ===== src/ccsd_if.sv =====
// Channel interfaces: chain code input, descriptor result and register write.
interface ccsd_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] code;
  logic       final_code;
  modport source (output valid, code, final_code, input ready);
  modport sink (input valid, code, final_code, output ready);
endinterface

interface ccsd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] even_steps;
  logic [15:0] odd_steps;
  logic [24:0] perimeter_q8;
  logic [25:0] area_twice;
  logic [32:0] area_border_q8;
  logic [24:0] pixel_count;
  logic [11:0] box_min_x;
  logic [11:0] box_max_x;
  logic [11:0] box_min_y;
  logic [11:0] box_max_y;
  logic        query_inside;
  modport source (output valid, even_steps, odd_steps, perimeter_q8, area_twice,
                  area_border_q8, pixel_count, box_min_x, box_max_x, box_min_y,
                  box_max_y, query_inside, input ready);
  modport sink (input valid, even_steps, odd_steps, perimeter_q8, area_twice,
                area_border_q8, pixel_count, box_min_x, box_max_x, box_min_y,
                box_max_y, query_inside, output ready);
endinterface

interface ccsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/chain_code_shape_descriptors_core.sv =====
// Top level of the chain code shape descriptor block: register file and stage wiring.
//
//   channel | dir | handshake     | payload
//   in_ch   | in  | valid/ready   | code, final_code
//   out_ch  | out | valid/ready   | step counts, perimeter, areas, pixel count, box, inside
//   cfg_ch  | in  | valid/ready   | index, data (start_x, start_y, query_x, query_y)
//
// One chain code request per cycle unless a final code is held. A final code loads the
// input register when accepted, closes the sums into the raw result register and then
// reaches the output register, each held while the next is full. Non-final codes keep
// flowing while a result waits. rst_n is synchronous; cfg_ch is always ready.
module chain_code_shape_descriptors_core
  import ccsd_pkg::*;
(
  input logic clk,
  input logic rst_n,
  ccsd_in_if.sink    in_ch,
  ccsd_out_if.source out_ch,
  ccsd_cfg_if.sink   cfg_ch
);

  cfg_t cfg_r, cfg_nxt;
  logic raw_valid, raw_ready;
  raw_t raw;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_START_X: cfg_nxt.start_x = cfg_ch.data;
        CFG_START_Y: cfg_nxt.start_y = cfg_ch.data;
        CFG_QUERY_X: cfg_nxt.query_x = cfg_ch.data;
        CFG_QUERY_Y: cfg_nxt.query_y = cfg_ch.data;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ccsd_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_code   (in_ch.code),
    .in_final  (in_ch.final_code),
    .raw_valid (raw_valid),
    .raw_ready (raw_ready),
    .raw       (raw)
  );

  ccsd_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .raw_valid (raw_valid),
    .raw_ready (raw_ready),
    .raw       (raw),
    .out_ch    (out_ch)
  );

endmodule

// ===== src/ccsd_accum.sv =====
// Input register, contour walk accumulators and the raw result register.
module ccsd_accum
  import ccsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_code,
  input  logic       in_final,
  output logic       raw_valid,
  input  logic       raw_ready,
  output raw_t       raw
);

  logic       s1_v_r, s1_v_nxt;
  logic [2:0] s1_code_r;
  logic       s1_fin_r;

  logic                      seen_r, seen_nxt;
  logic [2:0]                first_dir_r, first_dir_nxt;
  logic [2:0]                prev_r, prev_nxt;
  logic                      fv_r, fv_nxt, fj_r, fj_nxt;
  logic signed [POS_W-1:0]   pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic signed [CNT_W:0]     rel_y_r, rel_y_nxt;
  logic [CNT_W-1:0]          step_r, step_nxt, diag_r, diag_nxt;
  logic signed [AREA_W-1:0]  area_r, area_nxt, pix_r, pix_nxt;
  logic signed [CROSS_W-1:0] cross_r, cross_nxt;
  logic signed [POS_W-1:0]   bmin_x_r, bmax_x_r, bmin_y_r, bmax_y_r;
  logic signed [POS_W-1:0]   bmin_x_nxt, bmax_x_nxt, bmin_y_nxt, bmax_y_nxt;

  logic s2_v_r, s2_v_nxt;
  raw_t raw_r, raw_nxt;

  logic       s2_free, acc_take, drop, first;
  logic [2:0] c, fd;
  logic signed [1:0] dx, dy;
  logic signed [POS_W-1:0]  bx, by, qx, qy, nx, ny;
  logic signed [POS_W-1:0]  lo_x, hi_x, lo_y, hi_y;
  logic                     v, j, fv_use, fj_use;
  logic signed [AREA_W-1:0] ry, ay, area_add, pix_add, pix_close;
  logic signed [CROSS_W-1:0] cross_add, cross_close;
  logic [1:0]               ct, ct_close;

  assign s2_free  = !s2_v_r || raw_ready;
  assign acc_take = s1_v_r && (!s1_fin_r || s2_free);
  assign in_ready = !s1_v_r || acc_take;
  assign raw_valid = s2_v_r;
  assign raw       = raw_r;

  always_comb begin
    c     = s1_code_r;
    first = !seen_r;
    drop  = !s1_fin_r && (step_r >= CODE_LIMIT);
    dx    = STEP_DX[c];
    dy    = STEP_DY[c];
    bx    = first ? POS_W'(cfg.start_x) : pos_x_r;
    by    = first ? POS_W'(cfg.start_y) : pos_y_r;
    qx    = POS_W'(cfg.query_x);
    qy    = POS_W'(cfg.query_y);
    v     = (bx >= qx) && (by == qy);
    j     = (bx == qx) && (by == qy);
    fd     = first ? c : first_dir_r;
    fv_use = first ? v : fv_r;
    fj_use = first ? j : fj_r;
    lo_x  = first ? bx : bmin_x_r;
    hi_x  = first ? bx : bmax_x_r;
    lo_y  = first ? by : bmin_y_r;
    hi_y  = first ? by : bmax_y_r;

    ry = AREA_W'(rel_y_r);
    ay = (ry <<< 1) + AREA_W'(dy);
    case (dx)
      2'sd1:   area_add = ay;
      -2'sd1:  area_add = -ay;
      default: area_add = '0;
    endcase

    ct = CORNER_TYPE[prev_r][c];
    case (ct)
      CT_DEC:  pix_add = -ry;
      CT_INC:  pix_add = ry + AREA_W'(1);
      CT_ONE:  pix_add = AREA_W'(1);
      default: pix_add = '0;
    endcase
    if (first) begin
      pix_add = '0;
    end
    cross_add = first ? '0 : cross_term(v, j, prev_r, c);

    ct_close    = CORNER_TYPE[c][fd];
    pix_close   = (ct_close == CT_INC || ct_close == CT_ONE) ? AREA_W'(1) : '0;
    cross_close = cross_term(fv_use, fj_use, c, fd);

    nx = bx + POS_W'(dx);
    ny = by + POS_W'(dy);

    area_nxt  = area_r + area_add;
    pix_nxt   = pix_r + pix_add + (s1_fin_r ? pix_close : '0);
    cross_nxt = cross_r + cross_add + (s1_fin_r ? cross_close : '0);
    step_nxt  = step_r + CNT_W'(1);
    diag_nxt  = diag_r + CNT_W'(c[0]);
    rel_y_nxt = rel_y_r + (CNT_W + 1)'(dy);
    pos_x_nxt = nx;
    pos_y_nxt = ny;
    prev_nxt  = c;
    first_dir_nxt = fd;
    fv_nxt    = fv_use;
    fj_nxt    = fj_use;
    seen_nxt  = 1'b1;

    bmin_x_nxt = (nx < lo_x) ? nx : lo_x;
    bmax_x_nxt = (nx > hi_x) ? nx : hi_x;
    bmin_y_nxt = (ny < lo_y) ? ny : lo_y;
    bmax_y_nxt = (ny > hi_y) ? ny : hi_y;

    raw_nxt.even     = step_nxt - diag_nxt;
    raw_nxt.odd      = diag_nxt;
    raw_nxt.area     = area_nxt;
    raw_nxt.pix      = pix_nxt;
    raw_nxt.min_x    = lo_x;
    raw_nxt.max_x    = hi_x;
    raw_nxt.min_y    = lo_y;
    raw_nxt.max_y    = hi_y;
    raw_nxt.enclosed = (cross_nxt != '0);

    s1_v_nxt = in_valid ? 1'b1 : (s1_v_r && !acc_take);
    if (acc_take && s1_fin_r) begin
      s2_v_nxt = 1'b1;
    end else if (raw_ready) begin
      s2_v_nxt = 1'b0;
    end else begin
      s2_v_nxt = s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      seen_r      <= 1'b0;
      first_dir_r <= '0;
      prev_r      <= '0;
      fv_r        <= 1'b0;
      fj_r        <= 1'b0;
      rel_y_r     <= '0;
      step_r      <= '0;
      diag_r      <= '0;
      area_r      <= '0;
      pix_r       <= '0;
      cross_r     <= '0;
    end else begin
      if (in_ready) begin
        s1_v_r <= s1_v_nxt;
      end
      s2_v_r <= s2_v_nxt;
      if (acc_take && !drop) begin
        if (s1_fin_r) begin
          // contour closed: clear for the next one
          seen_r      <= 1'b0;
          first_dir_r <= '0;
          prev_r      <= '0;
          fv_r        <= 1'b0;
          fj_r        <= 1'b0;
          rel_y_r     <= '0;
          step_r      <= '0;
          diag_r      <= '0;
          area_r      <= '0;
          pix_r       <= '0;
          cross_r     <= '0;
        end else begin
          seen_r      <= seen_nxt;
          first_dir_r <= first_dir_nxt;
          prev_r      <= prev_nxt;
          fv_r        <= fv_nxt;
          fj_r        <= fj_nxt;
          rel_y_r     <= rel_y_nxt;
          step_r      <= step_nxt;
          diag_r      <= diag_nxt;
          area_r      <= area_nxt;
          pix_r       <= pix_nxt;
          cross_r     <= cross_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_code_r <= in_code;
      s1_fin_r  <= in_final;
    end
    if (acc_take && !drop && !s1_fin_r) begin
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
      bmin_x_r <= bmin_x_nxt;
      bmax_x_r <= bmax_x_nxt;
      bmin_y_r <= bmin_y_nxt;
      bmax_y_r <= bmax_y_nxt;
    end
    if (acc_take && s1_fin_r) begin
      raw_r <= raw_nxt;
    end
  end

endmodule

// ===== src/ccsd_post.sv =====
// Result formatting: magnitudes, weighted perimeter, saturation and the output register.
module ccsd_post
  import ccsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic raw_valid,
  output logic raw_ready,
  input  raw_t raw,
  ccsd_out_if.source out_ch
);

  logic out_v_r, out_v_nxt;

  logic [STEPS_W-1:0] even_r, even_nxt, odd_r, odd_nxt;
  logic [PER_W-1:0]   per_r, per_nxt;
  logic [AT_W-1:0]    at_r, at_nxt;
  logic [AB_W-1:0]    ab_r, ab_nxt;
  logic [PIX_W-1:0]   pix_r, pix_nxt;
  logic [BOX_W-1:0]   min_x_r, max_x_r, min_y_r, max_y_r;
  logic [BOX_W-1:0]   min_x_nxt, max_x_nxt, min_y_nxt, max_y_nxt;
  logic               inside_r;

  logic [AREA_W-1:0]     area_mag, pix_mag;
  logic [PER_CALC_W-1:0] per_full;
  logic [AB_CALC_W-1:0]  ab_full;
  logic                  area_big;

  function automatic logic [BOX_W-1:0] clamp_coord(input logic signed [POS_W-1:0] p);
    logic [BOX_W-1:0] r;
    if (p < 0) begin
      r = '0;
    end else if (p > COORD_TOP) begin
      r = BOX_W'(COORD_TOP);
    end else begin
      r = p[BOX_W-1:0];
    end
    return r;
  endfunction

  assign raw_ready = !out_v_r || out_ch.ready;

  always_comb begin
    area_mag = raw.area[AREA_W-1] ? AREA_W'(-raw.area) : AREA_W'(raw.area);
    pix_mag  = raw.pix[AREA_W-1] ? AREA_W'(-raw.pix) : AREA_W'(raw.pix);
    area_big = (area_mag[AREA_W-1:AT_W] != '0);

    per_full = (PER_CALC_W'(raw.even) << 8) + PER_CALC_W'(raw.odd) * PER_CALC_W'(362);
    ab_full  = (AB_CALC_W'(area_mag[AT_W-1:0]) << 7) + (AB_CALC_W'(raw.even) << 7)
             + AB_CALC_W'(raw.odd) * AB_CALC_W'(181);

    even_nxt = (raw.even > STEPS_MAX) ? STEPS_W'(STEPS_MAX) : raw.even[STEPS_W-1:0];
    odd_nxt  = (raw.odd > STEPS_MAX) ? STEPS_W'(STEPS_MAX) : raw.odd[STEPS_W-1:0];
    per_nxt  = (per_full > PER_MAX) ? PER_W'(PER_MAX) : per_full[PER_W-1:0];
    at_nxt   = (area_mag > AT_MAX) ? AT_W'(AT_MAX) : area_mag[AT_W-1:0];
    ab_nxt   = (area_big || ab_full > AB_MAX) ? AB_W'(AB_MAX) : ab_full[AB_W-1:0];
    pix_nxt  = (pix_mag > PIX_MAX) ? PIX_W'(PIX_MAX) : pix_mag[PIX_W-1:0];
    min_x_nxt = clamp_coord(raw.min_x);
    max_x_nxt = clamp_coord(raw.max_x);
    min_y_nxt = clamp_coord(raw.min_y);
    max_y_nxt = clamp_coord(raw.max_y);

    if (raw_valid && raw_ready) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_valid && raw_ready) begin
      even_r   <= even_nxt;
      odd_r    <= odd_nxt;
      per_r    <= per_nxt;
      at_r     <= at_nxt;
      ab_r     <= ab_nxt;
      pix_r    <= pix_nxt;
      min_x_r  <= min_x_nxt;
      max_x_r  <= max_x_nxt;
      min_y_r  <= min_y_nxt;
      max_y_r  <= max_y_nxt;
      inside_r <= raw.enclosed;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.even_steps     = even_r;
  assign out_ch.odd_steps      = odd_r;
  assign out_ch.perimeter_q8   = per_r;
  assign out_ch.area_twice     = at_r;
  assign out_ch.area_border_q8 = ab_r;
  assign out_ch.pixel_count    = pix_r;
  assign out_ch.box_min_x      = min_x_r;
  assign out_ch.box_max_x      = max_x_r;
  assign out_ch.box_min_y      = min_y_r;
  assign out_ch.box_max_y      = max_y_r;
  assign out_ch.query_inside   = inside_r;

endmodule
